// ===== rtl/core/rsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled mask mapper package
// Shared widths, reset values, register indexes and stage control types.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmm_pkg;

    // Default sizing of the mask memory and the used destination coordinate bits.
    localparam int MASK_DEPTH_DEF = 65536;
    localparam int COORD_BITS_DEF = 12;

    // Field and register widths.
    localparam int COEF_W     = 24;
    localparam int OFF_W      = 32;
    localparam int EXT_W      = 13;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_W     = 16;
    localparam int ROW_W      = 12;
    localparam int DST_IDX_W  = 25;
    localparam int SRC_IDX_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic signed [COEF_W-1:0] COS_RST      = 24'sd65536;
    localparam logic signed [COEF_W-1:0] SIN_RST      = 24'sd0;
    localparam logic signed [OFF_W-1:0]  OFF_ROW_RST  = 32'sd32768;
    localparam logic signed [OFF_W-1:0]  OFF_COL_RST  = 32'sd32768;
    localparam logic [EXT_W-1:0]         SRC_ROWS_RST = 13'd256;
    localparam logic [EXT_W-1:0]         SRC_COLS_RST = 13'd256;
    localparam logic [EXT_W-1:0]         DST_ROWS_RST = 13'd256;

    // Request types.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_SCALED = 3'd0,
        CFG_SIN_SCALED = 3'd1,
        CFG_OFFSET_ROW = 3'd2,
        CFG_OFFSET_COL = 3'd3,
        CFG_SRC_ROWS   = 3'd4,
        CFG_SRC_COLS   = 3'd5,
        CFG_DST_ROWS   = 3'd6
    } cfg_index_t;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_map;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsmm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while the read enable is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rotated_scaled_mask_mapper.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled mask mapper
// Maps destination pixels back into a rotated, scaled source image and
// reports those that land on an opaque pixel of a one-bit source mask.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | req_type, mask_addr, mask_bit, dst_row,
//           |                       | dst_col
//  out      | out_valid / out_ready | dst_index, src_index
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is accepted per clock while the skid register is empty.
// A map transaction enters the product stage at acceptance, then passes sums
// and floor, range check with index product, mask memory read and the output
// register. Load and map transactions access the mask memory in the same
// stage, so every read sees all earlier writes. Reset clears control state
// only; the mask holds no defined value until written and needs no clearing
// pass. The pipeline halts only when both the output register and its skid
// register hold results.
//
`default_nettype none

module rotated_scaled_mask_mapper
    import rsmm_pkg::*;
#(
    parameter int MASK_DEPTH = MASK_DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  req_type,
    input  wire logic [ADDR_W-1:0]     mask_addr,
    input  wire logic                  mask_bit,
    input  wire logic [ROW_W-1:0]      dst_row,
    input  wire logic [ROW_W-1:0]      dst_col,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DST_IDX_W-1:0]       dst_index,
    output logic [SRC_IDX_W-1:0]       src_index,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = $clog2(MASK_DEPTH);
    localparam int RB     = (COORD_BITS < ROW_W) ? COORD_BITS : ROW_W;
    localparam int PW     = COEF_W + RB + 1;
    localparam int SW     = ((PW > OFF_W) ? PW : OFF_W) + 2;
    localparam int FW     = SW - FRAC_BITS;
    localparam int PROD_W = 2 * EXT_W;
    localparam int IW     = PROD_W + 1;
    localparam int LW     = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int DP_W   = RB + EXT_W;

    localparam logic [LW-1:0] LOAD_LIMIT = LW'(MASK_DEPTH);
    localparam logic [IW-1:0] READ_LIMIT = IW'(MASK_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] cos_reg;
    logic signed [COEF_W-1:0] sin_reg;
    logic signed [OFF_W-1:0]  off_row_reg;
    logic signed [OFF_W-1:0]  off_col_reg;
    logic [EXT_W-1:0]         src_rows_reg;
    logic [EXT_W-1:0]         src_cols_reg;
    logic [EXT_W-1:0]         dst_rows_reg;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= COS_RST;
            sin_reg      <= SIN_RST;
            off_row_reg  <= OFF_ROW_RST;
            off_col_reg  <= OFF_COL_RST;
            src_rows_reg <= SRC_ROWS_RST;
            src_cols_reg <= SRC_COLS_RST;
            dst_rows_reg <= DST_ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COS_SCALED: cos_reg      <= cfg_data[COEF_W-1:0];
                CFG_SIN_SCALED: sin_reg      <= cfg_data[COEF_W-1:0];
                CFG_OFFSET_ROW: off_row_reg  <= cfg_data[OFF_W-1:0];
                CFG_OFFSET_COL: off_col_reg  <= cfg_data[OFF_W-1:0];
                CFG_SRC_ROWS:   src_rows_reg <= cfg_data[EXT_W-1:0];
                CFG_SRC_COLS:   src_cols_reg <= cfg_data[EXT_W-1:0];
                CFG_DST_ROWS:   dst_rows_reg <= cfg_data[EXT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: the pipeline moves unless the skid register is full.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: coordinate products and load address check
    // ------------------------------------------------------------------
    logic [RB-1:0]          row0;
    logic [RB-1:0]          col0;
    logic signed [RB:0]     row0_s;
    logic signed [RB:0]     col0_s;
    logic [LW-1:0]          load_addr0;
    stage_ctl_t             s1_ctl_next;
    logic signed [PW-1:0]   s1_pcr_next;
    logic signed [PW-1:0]   s1_psc_next;
    logic signed [PW-1:0]   s1_pcc_next;
    logic signed [PW-1:0]   s1_psr_next;
    logic [DP_W-1:0]        s1_dprod_next;
    logic                   s1_wok_next;

    stage_ctl_t             s1_ctl_reg;
    logic signed [PW-1:0]   s1_pcr_reg;
    logic signed [PW-1:0]   s1_psc_reg;
    logic signed [PW-1:0]   s1_pcc_reg;
    logic signed [PW-1:0]   s1_psr_reg;
    logic [RB-1:0]          s1_row_reg;
    logic [DP_W-1:0]        s1_dprod_reg;
    logic                   s1_wok_reg;
    logic [AW-1:0]          s1_waddr_reg;
    logic                   s1_wbit_reg;

    assign row0       = dst_row[RB-1:0];
    assign col0       = dst_col[RB-1:0];
    assign row0_s     = $signed({1'b0, row0});
    assign col0_s     = $signed({1'b0, col0});
    assign load_addr0 = LW'(mask_addr);

    assign s1_ctl_next.valid  = in_valid;
    assign s1_ctl_next.is_map = (req_type == REQ_MAP);
    assign s1_pcr_next        = cos_reg * row0_s;
    assign s1_psc_next        = sin_reg * col0_s;
    assign s1_pcc_next        = cos_reg * col0_s;
    assign s1_psr_next        = sin_reg * row0_s;
    assign s1_dprod_next      = col0 * dst_rows_reg;
    assign s1_wok_next        = (load_addr0 < LOAD_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pcr_reg   <= s1_pcr_next;
            s1_psc_reg   <= s1_psc_next;
            s1_pcc_reg   <= s1_pcc_next;
            s1_psr_reg   <= s1_psr_next;
            s1_row_reg   <= row0;
            s1_dprod_reg <= s1_dprod_next;
            s1_wok_reg   <= s1_wok_next;
            s1_waddr_reg <= load_addr0[AW-1:0];
            s1_wbit_reg  <= mask_bit;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: source coordinate sums, floor, destination index
    // ------------------------------------------------------------------
    logic signed [SW-1:0]    sum_r1;
    logic signed [SW-1:0]    sum_c1;
    logic [DST_IDX_W-1:0]    s2_dst_next;

    stage_ctl_t              s2_ctl_reg;
    logic signed [FW-1:0]    s2_sr_reg;
    logic signed [FW-1:0]    s2_sc_reg;
    logic [DST_IDX_W-1:0]    s2_dst_reg;
    logic                    s2_wok_reg;
    logic [AW-1:0]           s2_waddr_reg;
    logic                    s2_wbit_reg;

    assign sum_r1 = SW'(s1_pcr_reg) + SW'(s1_psc_reg) + SW'(off_row_reg);
    assign sum_c1 = SW'(s1_pcc_reg) - SW'(s1_psr_reg) + SW'(off_col_reg);
    assign s2_dst_next = DST_IDX_W'(s1_dprod_reg) + DST_IDX_W'(s1_row_reg)
                       + DST_IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else if (en)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // Dropping the fraction bits of a two's complement value rounds toward
    // minus infinity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sr_reg    <= sum_r1[SW-1:FRAC_BITS];
            s2_sc_reg    <= sum_c1[SW-1:FRAC_BITS];
            s2_dst_reg   <= s2_dst_next;
            s2_wok_reg   <= s1_wok_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_wbit_reg  <= s1_wbit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: bounds check and column times source rows
    // ------------------------------------------------------------------
    logic                    row_in2;
    logic                    col_in2;
    logic [PROD_W-1:0]       s3_prod_next;

    stage_ctl_t              s3_ctl_reg;
    logic                    s3_inside_reg;
    logic [PROD_W-1:0]       s3_prod_reg;
    logic [EXT_W-1:0]        s3_sr_reg;
    logic [DST_IDX_W-1:0]    s3_dst_reg;
    logic                    s3_wok_reg;
    logic [AW-1:0]           s3_waddr_reg;
    logic                    s3_wbit_reg;

    assign row_in2 = !s2_sr_reg[FW-1]
                   && (s2_sr_reg[FW-2:0] < (FW-1)'(src_rows_reg));
    assign col_in2 = !s2_sc_reg[FW-1]
                   && (s2_sc_reg[FW-2:0] < (FW-1)'(src_cols_reg));
    assign s3_prod_next = s2_sc_reg[EXT_W-1:0] * src_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_inside_reg <= row_in2 && col_in2;
            s3_prod_reg   <= s3_prod_next;
            s3_sr_reg     <= s2_sr_reg[EXT_W-1:0];
            s3_dst_reg    <= s2_dst_reg;
            s3_wok_reg    <= s2_wok_reg;
            s3_waddr_reg  <= s2_waddr_reg;
            s3_wbit_reg   <= s2_wbit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: mask memory access. Loads write and maps read here, in
    // transaction order, so no forwarding is needed.
    // ------------------------------------------------------------------
    logic [IW-1:0]           ndx3;
    logic                    in_mask3;
    logic                    cand3;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic                    ram_rd_data;

    logic                    s4_valid_reg;
    logic                    s4_cand_reg;
    logic [DST_IDX_W-1:0]    s4_dst_reg;
    logic [SRC_IDX_W-1:0]    s4_src_reg;

    assign ndx3      = IW'(s3_sr_reg) + IW'(s3_prod_reg);
    assign in_mask3  = (ndx3 < READ_LIMIT);
    assign cand3     = s3_ctl_reg.is_map && s3_inside_reg && in_mask3;
    assign ram_rd_en = en && s3_ctl_reg.valid && cand3;
    assign ram_wr_en = en && s3_ctl_reg.valid && !s3_ctl_reg.is_map && s3_wok_reg;

    rsmm_ram #(
        .WIDTH (1),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s3_waddr_reg),
        .wr_data (s3_wbit_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ndx3[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_cand_reg <= cand3;
            s4_dst_reg  <= s3_dst_reg;
            s4_src_reg  <= ndx3[SRC_IDX_W-1:0] + SRC_IDX_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid register
    // ------------------------------------------------------------------
    logic                    push;
    logic                    out_load;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DST_IDX_W-1:0]    out_dst_reg;
    logic [DST_IDX_W-1:0]    out_dst_next;
    logic [SRC_IDX_W-1:0]    out_src_reg;
    logic [SRC_IDX_W-1:0]    out_src_next;
    logic                    skid_valid_next;
    logic [DST_IDX_W-1:0]    skid_dst_reg;
    logic [DST_IDX_W-1:0]    skid_dst_next;
    logic [SRC_IDX_W-1:0]    skid_src_reg;
    logic [SRC_IDX_W-1:0]    skid_src_next;

    assign push     = en && s4_valid_reg && s4_cand_reg && ram_rd_data;
    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_dst_next    = out_dst_reg;
        out_src_next    = out_src_reg;
        skid_valid_next = skid_valid_reg;
        skid_dst_next   = skid_dst_reg;
        skid_src_next   = skid_src_reg;
        priority if (out_load && skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_dst_next    = skid_dst_reg;
            out_src_next    = skid_src_reg;
            skid_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            out_valid_next = push;
            out_dst_next   = s4_dst_reg;
            out_src_next   = s4_src_reg;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_dst_next   = s4_dst_reg;
            skid_src_next   = s4_src_reg;
        end
        else
        begin
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dst_reg  <= out_dst_next;
        out_src_reg  <= out_src_next;
        skid_dst_reg <= skid_dst_next;
        skid_src_reg <= skid_src_next;
    end

    assign out_valid = out_valid_reg;
    assign dst_index = out_dst_reg;
    assign src_index = out_src_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsmm_props.sv =====
// ----------------------------------------------------------------------------
// Rotated scaled mask mapper properties
// Port-level assertions on result holding, result values and stall recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmm_props
    import rsmm_pkg::*;
#(
    parameter int MASK_DEPTH = MASK_DEPTH_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [DST_IDX_W-1:0] dst_index,
    input wire logic [SRC_IDX_W-1:0] src_index
);

    localparam logic SRC_WRAPS = (MASK_DEPTH > (1 << (SRC_IDX_W - 1)));

    // A stalled result stays and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dst_index)
                                    && $stable(src_index))
        else $error("result changed while stalled");

    // The destination index is one-based and cannot wrap to zero.
    a_dst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dst_index != '0)
        else $error("destination index is zero");

    // The source index is one-based unless the mask exceeds its range.
    a_src_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> SRC_WRAPS || src_index != '0)
        else $error("source index is zero");

    // Input is only refused while results wait at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input refused without a waiting result");

    // Taking a result while stalled frees the input side in the next cycle.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("input side stayed stalled after a result was taken");

endmodule

bind rotated_scaled_mask_mapper rsmm_props #(
    .MASK_DEPTH (MASK_DEPTH)
) u_rsmm_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dst_index (dst_index),
    .src_index (src_index)
);

`default_nettype wire
